// File: rtl/core/mhpq_pkg.sv
// Shared types and constants for the min-heap priority queue core.
`default_nettype none

package mhpq_pkg;

   localparam int DEPTH  = 1024;
   localparam int DATA_W = 32;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = ADDR_W + 1;

   localparam logic [CNT_W-1:0] DEPTH_COUNT = CNT_W'(DEPTH);

   localparam logic [1:0] FUNC_PUSH  = 2'd0;
   localparam logic [1:0] FUNC_POP   = 2'd1;
   localparam logic [1:0] FUNC_CLEAR = 2'd2;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   // Commands from the controller to the datapath, at most one per cycle.
   typedef struct packed {
      logic load_push;     // latch the pushed value, position = count, count + 1
      logic load_pop;      // count - 1, read the last entry
      logic clear;         // count = 0
      logic take_last;     // latch the last entry as the moving value, position = root
      logic rd_parent;     // read the parent of the current position
      logic rd_children;   // read both children of the current position
      logic wr_value;      // write the moving value at the current position
      logic wr_up_move;    // write the parent down here, climb to the parent
      logic wr_down_move;  // write the smaller child up here, descend to it
   } dp_cmd_type;

   // Status from the datapath back to the controller.
   typedef struct packed {
      logic full;
      logic empty;
      logic at_root;
      logic left_out;
      logic up_less;
      logic down_less;
   } dp_status_type;

endpackage

`default_nettype wire

// File: rtl/core/mhpq_datapath.sv
// Datapath of the heap: entry store, count, sift position and moving value.
`default_nettype none

module mhpq_datapath (
   input  wire                              clock,
   input  wire                              reset,
   input  wire  mhpq_pkg::dp_cmd_type       cmd,
   input  wire  signed [mhpq_pkg::DATA_W-1:0] push_value,
   output mhpq_pkg::dp_status_type          status,
   output logic signed [mhpq_pkg::DATA_W-1:0] top_value,
   output logic        [mhpq_pkg::CNT_W-1:0]  entry_count,
   output logic                             is_empty
);

   logic signed [mhpq_pkg::DATA_W-1:0] heap_mem [mhpq_pkg::DEPTH];

   logic        [mhpq_pkg::CNT_W-1:0]  count_ff, count_in;
   logic        [mhpq_pkg::ADDR_W-1:0] pos_ff, pos_in;
   logic signed [mhpq_pkg::DATA_W-1:0] val_ff, val_in;
   logic signed [mhpq_pkg::DATA_W-1:0] root_ff;
   logic signed [mhpq_pkg::DATA_W-1:0] rd_a_ff, rd_b_ff;

   logic        [mhpq_pkg::ADDR_W-1:0] parent_idx;
   logic        [mhpq_pkg::CNT_W-1:0]  left_idx, right_idx, last_idx;
   logic        [mhpq_pkg::ADDR_W-1:0] rd_addr_a, rd_addr_b;
   logic                               right_in, pick_right;
   logic        [mhpq_pkg::ADDR_W-1:0] pick_idx;
   logic signed [mhpq_pkg::DATA_W-1:0] pick_val;
   logic                               wr_en;
   logic signed [mhpq_pkg::DATA_W-1:0] wr_data;

   assign parent_idx = (pos_ff - mhpq_pkg::ADDR_W'(1)) >> 1;
   assign left_idx   = {pos_ff, 1'b1};
   assign right_idx  = left_idx + mhpq_pkg::CNT_W'(1);
   assign last_idx   = count_ff - mhpq_pkg::CNT_W'(1);

   // On equal children the left one wins.
   assign right_in   = right_idx < count_ff;
   assign pick_right = right_in && (rd_b_ff < rd_a_ff);
   assign pick_idx   = pick_right ? right_idx[mhpq_pkg::ADDR_W-1:0]
                                  : left_idx[mhpq_pkg::ADDR_W-1:0];
   assign pick_val   = pick_right ? rd_b_ff : rd_a_ff;

   // With no sift read requested, port A fetches the last entry for a pop.
   always_comb begin
      if (cmd.rd_parent) begin
         rd_addr_a = parent_idx;
      end else if (cmd.rd_children) begin
         rd_addr_a = left_idx[mhpq_pkg::ADDR_W-1:0];
      end else begin
         rd_addr_a = last_idx[mhpq_pkg::ADDR_W-1:0];
      end
   end
   assign rd_addr_b = right_idx[mhpq_pkg::ADDR_W-1:0];

   assign wr_en = cmd.wr_value | cmd.wr_up_move | cmd.wr_down_move;

   always_comb begin
      if (cmd.wr_up_move) begin
         wr_data = rd_a_ff;
      end else if (cmd.wr_down_move) begin
         wr_data = pick_val;
      end else begin
         wr_data = val_ff;
      end
   end

   always_comb begin
      count_in = count_ff;
      pos_in   = pos_ff;
      val_in   = val_ff;
      if (cmd.load_push) begin
         count_in = count_ff + mhpq_pkg::CNT_W'(1);
         pos_in   = count_ff[mhpq_pkg::ADDR_W-1:0];
         val_in   = push_value;
      end
      if (cmd.load_pop) begin
         count_in = last_idx;
      end
      if (cmd.clear) begin
         count_in = '0;
      end
      if (cmd.take_last) begin
         pos_in = '0;
         val_in = rd_a_ff;
      end
      if (cmd.wr_up_move) begin
         pos_in = parent_idx;
      end
      if (cmd.wr_down_move) begin
         pos_in = pick_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      val_ff <= val_in;
      if (wr_en && (pos_ff == '0)) begin
         root_ff <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         heap_mem[pos_ff] <= wr_data;
      end
      rd_a_ff <= heap_mem[rd_addr_a];
      rd_b_ff <= heap_mem[rd_addr_b];
   end

   assign status.full      = count_ff == mhpq_pkg::DEPTH_COUNT;
   assign status.empty     = count_ff == '0;
   assign status.at_root   = pos_ff == '0;
   assign status.left_out  = left_idx >= count_ff;
   assign status.up_less   = val_ff < rd_a_ff;
   assign status.down_less = pick_val < val_ff;

   assign top_value   = (count_ff == '0) ? '0 : root_ff;
   assign entry_count = count_ff;
   assign is_empty    = count_ff == '0;

endmodule

`default_nettype wire

// File: rtl/core/mhpq_controller.sv
// Sequencing state machine for push, pop and clear transactions.
`default_nettype none

module mhpq_controller (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        start,
   input  wire  [1:0]                 func,
   input  wire  mhpq_pkg::dp_status_type dp_status,
   output mhpq_pkg::dp_cmd_type       cmd,
   output logic                       busy,
   output logic                       rsp_valid,
   output logic [1:0]                 rsp_status
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UP_CHK,
      ST_UP_CMP,
      ST_DN_LOAD,
      ST_DN_CHK,
      ST_DN_CMP
   } state_type;

   state_type  state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] status_ff, status_in;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      status_in    = status_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               rsp_valid_in = 1'b1;
               status_in    = mhpq_pkg::STATUS_OK;
               case (func)
                  mhpq_pkg::FUNC_PUSH: begin
                     if (dp_status.full) begin
                        status_in = mhpq_pkg::STATUS_FULL;
                     end else begin
                        cmd.load_push = 1'b1;
                        rsp_valid_in  = 1'b0;
                        state_in      = ST_UP_CHK;
                     end
                  end
                  mhpq_pkg::FUNC_POP: begin
                     if (dp_status.empty) begin
                        status_in = mhpq_pkg::STATUS_EMPTY;
                     end else begin
                        cmd.load_pop = 1'b1;
                        rsp_valid_in = 1'b0;
                        state_in     = ST_DN_LOAD;
                     end
                  end
                  mhpq_pkg::FUNC_CLEAR: begin
                     cmd.clear = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_UP_CHK: begin
            if (dp_status.at_root) begin
               cmd.wr_value = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               cmd.rd_parent = 1'b1;
               state_in      = ST_UP_CMP;
            end
         end
         ST_UP_CMP: begin
            if (dp_status.up_less) begin
               cmd.wr_up_move = 1'b1;
               state_in       = ST_UP_CHK;
            end else begin
               cmd.wr_value = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_DN_LOAD: begin
            cmd.take_last = 1'b1;
            state_in      = ST_DN_CHK;
         end
         ST_DN_CHK: begin
            if (dp_status.left_out) begin
               cmd.wr_value = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               cmd.rd_children = 1'b1;
               state_in        = ST_DN_CMP;
            end
         end
         ST_DN_CMP: begin
            if (dp_status.down_less) begin
               cmd.wr_down_move = 1'b1;
               state_in         = ST_DN_CHK;
            end else begin
               cmd.wr_value = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         status_ff    <= mhpq_pkg::STATUS_OK;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         status_ff    <= status_in;
      end
   end

   assign busy       = state_ff != ST_IDLE;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = status_ff;

endmodule

`default_nettype wire

// File: rtl/core/min_heap_priority_queue_core.sv
// Top level of the min-heap priority queue: controller, datapath and checks.
//
// A transaction is accepted at a rising edge where start is high and busy is low;
// req_func selects push, pop of the minimum, or clear, and req_push_value carries
// the value to insert on a push. Every transaction returns exactly one result,
// shown for a single cycle while rsp_valid is high: the smallest stored value
// (zero when empty), the entry count, an empty flag and a status. The receiver
// cannot hold a result off, so it must take it in the cycle it appears. Clear,
// the unused code and rejected operations (push when full, pop when empty)
// answer in the cycle after acceptance. A push or pop walks the new or moved
// entry level by level, up towards the root or down towards a leaf, until it
// reaches the end or a compare stops it. A push moves at most 10 levels and a
// pop at most 9 with 1024 entries. As the entry store has a single write port,
// each level first reads the parent or both children and then compares and
// writes back. The next transaction may be started in the cycle that shows the
// result. The store is not cleared; only entries below the count are ever used.
`default_nettype none

module min_heap_priority_queue_core (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                start,
   output logic                               busy,
   input  wire         [1:0]                  req_func,
   input  wire  signed [31:0]                 req_push_value,
   output logic                               rsp_valid,
   output logic signed [31:0]                 rsp_top_value,
   output logic        [10:0]                 rsp_entry_count,
   output logic                               rsp_is_empty,
   output logic        [1:0]                  rsp_status
);

   mhpq_pkg::dp_cmd_type    cmd;
   mhpq_pkg::dp_status_type dp_status;

   // The controller walks the sift loops and issues at most one datapath command per cycle.
   mhpq_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .func       (req_func),
      .dp_status  (dp_status),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_valid  (rsp_valid),
      .rsp_status (rsp_status)
   );

   // The datapath holds the entry store and reports the comparisons the
   // controller branches on.
   mhpq_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .push_value  (req_push_value),
      .status      (dp_status),
      .top_value   (rsp_top_value),
      .entry_count (rsp_entry_count),
      .is_empty    (rsp_is_empty)
   );

   // A result is only ever shown while the block is ready for the next transaction.
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> !busy)
      else $error("result shown while busy");

   // A rejected push reports a full heap.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == mhpq_pkg::STATUS_FULL))
         |-> (rsp_entry_count == mhpq_pkg::DEPTH_COUNT))
      else $error("push rejected while not full");

   // A rejected pop reports an empty heap with a zero minimum.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == mhpq_pkg::STATUS_EMPTY))
         |-> (rsp_is_empty && (rsp_top_value == '0)))
      else $error("pop rejected while not empty");

   // A clear answers in the next cycle with an empty heap.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_func == mhpq_pkg::FUNC_CLEAR))
         |=> (rsp_valid && (rsp_entry_count == '0)))
      else $error("clear did not empty the heap");

endmodule

`default_nettype wire
